>>> hdl/assert_macros.svh
// assertion macros shared by the scorer modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define LLS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lls assertion failed");
// expression must never be true outside reset
`define LLS_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lls forbidden condition seen");
`else
`define LLS_ASSERT(label, clk, rst, prop)
`define LLS_NEVER(label, clk, rst, expr)
`endif
`endif

>>> hdl/lls_pkg.sv
// types, constants and the sigmoid table of the linear/logistic scorer
// no dependencies; used by the interfaces and every scorer module
package lls_pkg;

  // sizes
  localparam int MAX_FEATURES = 64;
  localparam int VALUE_WIDTH  = 16;
  localparam int ADDR_W       = $clog2(MAX_FEATURES);
  localparam int WIDX_W       = 6;
  localparam int POS_W        = 7;
  localparam int PROD_W       = 2 * VALUE_WIDTH;
  localparam int ACC_W        = 48;
  localparam int SCORE_W      = 32;
  localparam int MARG_W       = ACC_W + 2;
  localparam int FRAC_SHIFT   = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // sigmoid interpolation
  localparam int SIG_FRAC_W = 16;
  localparam int SIG_IDX_W  = 3;
  localparam int SIG_W      = 16;
  localparam int SIG_PROD_W = 2 * SIG_W;

  localparam logic [POS_W-1:0]  POS_LIMIT  = '1;
  localparam logic [SIG_W:0]    ONE_Q16    = 17'h10000;
  localparam logic [SIG_W-1:0]  SIG_END    = 16'd65514;
  localparam logic [MARG_W-1:0] ROUND_HALF = MARG_W'(128);

  localparam logic [POS_W-1:0]  FC_RESET   = POS_W'(64);

  typedef enum logic {
    KIND_WEIGHT  = 1'b0,
    KIND_FEATURE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LEN       = 2'd0,
    REG_LOGISTIC_MODE = 2'd1,
    REG_BIAS          = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]          row_len;
    logic                      logistic_mode;
    logic signed [SCORE_W-1:0] bias;
  } cfg_t;

  // one feature on its way from the front to the accumulator
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] weight;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          acc_en;
    logic                          eor;
    logic                          err;
  } job_t;

  // round(65536 * sigmoid(k)) at unit steps
  function automatic logic [SIG_W-1:0] sig_point(input logic [SIG_IDX_W:0] k);
    logic [SIG_W-1:0] r;
    unique case (k)
      4'd0:    r = 16'd32768;
      4'd1:    r = 16'd47911;
      4'd2:    r = 16'd57724;
      4'd3:    r = 16'd62428;
      4'd4:    r = 16'd64357;
      4'd5:    r = 16'd65097;
      4'd6:    r = 16'd65374;
      4'd7:    r = 16'd65476;
      default: r = SIG_END;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/lls_ifs.sv
// valid/ready channel interfaces of the scorer: items, results, register writes
// depends on lls_pkg
interface lls_item_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [lls_pkg::WIDX_W-1:0]            weight_index;
  logic signed [lls_pkg::VALUE_WIDTH-1:0] value;
  logic                                  end_of_row;
  modport source (output valid, kind, weight_index, value, end_of_row, input ready);
  modport sink (input valid, kind, weight_index, value, end_of_row, output ready);
endinterface

interface lls_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [lls_pkg::SCORE_W-1:0] score;
  logic                               row_error;
  modport source (output valid, score, row_error, input ready);
  modport sink (input valid, score, row_error, output ready);
endinterface

interface lls_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lls_pkg::CFG_IDX_W-1:0]   index;
  logic [lls_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/lls_front.sv
// front end: takes items, keeps the weight table, counts row position,
// reads the weight and classifies each feature; depends on lls_pkg, lls_ifs
module lls_front (
  input  logic                 clk,
  input  logic                 rst,
  lls_item_if.sink             item,
  input  lls_pkg::cfg_t        cfg,
  output lls_pkg::job_t        push_data,
  output logic                 push,
  input  logic                 full
);

  logic signed [lls_pkg::VALUE_WIDTH-1:0] weights [lls_pkg::MAX_FEATURES];
  logic signed [lls_pkg::VALUE_WIDTH-1:0] rd_weight;
  logic signed [lls_pkg::VALUE_WIDTH-1:0] stg_value;
  logic                                   stg_acc_en;
  logic                                   stg_eor;
  logic                                   stg_err;
  logic                                   stg_valid;
  logic [lls_pkg::POS_W-1:0]              pos;
  logic [lls_pkg::POS_W-1:0]              count;
  logic                                   accept;
  logic                                   is_feature;
  logic                                   acc_en;
  logic                                   row_err;

  // handshake: the stage frees up when the queue takes its content
  assign item.ready = !stg_valid || !full;
  assign accept     = item.valid && item.ready;
  assign is_feature = lls_pkg::kind_t'(item.kind) == lls_pkg::KIND_FEATURE;
  assign push       = stg_valid && !full;

  // classify the feature at its row position
  always_comb begin
    count   = (pos < lls_pkg::POS_LIMIT) ? pos + 1'b1 : lls_pkg::POS_LIMIT;
    acc_en  = (int'(pos) < int'(cfg.row_len)) && (int'(pos) < lls_pkg::MAX_FEATURES);
    row_err = (count != cfg.row_len) || (count == lls_pkg::POS_LIMIT) ||
              (int'(cfg.row_len) > lls_pkg::MAX_FEATURES);
  end

  // weight table write and registered read
  always_ff @(posedge clk) begin
    if (accept && !is_feature && (int'(item.weight_index) < lls_pkg::MAX_FEATURES)) begin
      weights[item.weight_index[lls_pkg::ADDR_W-1:0]] <= item.value;
    end
    if (accept && is_feature) begin
      rd_weight <= weights[pos[lls_pkg::ADDR_W-1:0]];
    end
  end

  // row position and the stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      stg_valid <= 1'b0;
    end else begin
      if (accept && is_feature) begin
        stg_valid <= 1'b1;
        pos       <= item.end_of_row ? '0 : count;
      end else if (push) begin
        stg_valid <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept && is_feature) begin
      stg_value  <= item.value;
      stg_acc_en <= acc_en;
      stg_eor    <= item.end_of_row;
      stg_err    <= row_err;
    end
  end

  // queue entry
  always_comb begin
    push_data.weight = rd_weight;
    push_data.value  = stg_value;
    push_data.acc_en = stg_acc_en;
    push_data.eor    = stg_eor;
    push_data.err    = stg_err;
  end

endmodule

>>> hdl/lls_queue.sv
// short feature queue between front and back end
// depends on lls_pkg
`include "assert_macros.svh"
module lls_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lls_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output lls_pkg::job_t pop_data,
  output logic          empty
);

  lls_pkg::job_t                entries [lls_pkg::QUEUE_DEPTH];
  logic [lls_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lls_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lls_pkg::QPTR_W:0]     fill;

  assign full     = fill == (lls_pkg::QPTR_W + 1)'(lls_pkg::QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `LLS_NEVER(a_queue_overflow, clk, rst, push && full)
  `LLS_NEVER(a_queue_underflow, clk, rst, pop && empty)

endmodule

>>> hdl/lls_back.sv
// back end: multiply-accumulate per feature, then margin, sigmoid and result
// depends on lls_pkg, lls_ifs
`include "assert_macros.svh"
module lls_back (
  input  logic          clk,
  input  logic          rst,
  input  lls_pkg::cfg_t cfg,
  input  lls_pkg::job_t pop_data,
  input  logic          empty,
  output logic          pop,
  lls_result_if.source  result
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MARGIN,
    ST_SIGMOID,
    ST_EMIT
  } state_t;

  state_t                               state;
  logic                                 m_valid;
  logic signed [lls_pkg::PROD_W-1:0]    m_prod;
  logic                                 m_acc_en;
  logic                                 m_eor;
  logic                                 m_err;
  logic signed [lls_pkg::ACC_W-1:0]     acc;
  logic signed [lls_pkg::ACC_W-1:0]     fin_sum;
  logic                                 fin_err;
  logic signed [lls_pkg::SCORE_W-1:0]   margin;
  logic [lls_pkg::SIG_PROD_W-1:0]       sig_prod;
  logic [lls_pkg::SIG_W-1:0]            sig_base;
  logic                                 sig_big;
  logic                                 sig_neg;
  logic                                 out_valid;
  logic signed [lls_pkg::SCORE_W-1:0]   out_score;
  logic                                 out_err;

  logic signed [lls_pkg::ACC_W:0]       acc_sum;
  logic signed [lls_pkg::ACC_W-1:0]     acc_sat;
  logic signed [lls_pkg::MARG_W-1:0]    marg_full;
  logic signed [lls_pkg::MARG_W-lls_pkg::FRAC_SHIFT-1:0] marg_q16;
  logic signed [lls_pkg::SCORE_W-1:0]   marg_sat;
  logic signed [lls_pkg::SCORE_W:0]     marg_ext;
  logic [lls_pkg::SCORE_W:0]            mag;
  logic [lls_pkg::SIG_IDX_W-1:0]        sig_idx;
  logic [lls_pkg::SIG_W-1:0]            base_pt;
  logic [lls_pkg::SIG_W-1:0]            diff_pt;
  logic [lls_pkg::SIG_PROD_W:0]         rounded;
  logic [lls_pkg::SIG_W:0]              interp;
  logic [lls_pkg::SIG_W:0]              prob;
  logic signed [lls_pkg::SCORE_W-1:0]   score_next;
  logic                                 out_free;

  assign pop       = (state == ST_RUN) && !empty;
  assign out_free  = !out_valid || result.ready;

  assign result.valid     = out_valid;
  assign result.score     = out_score;
  assign result.row_error = out_err;

  // saturating accumulate of the staged product
  always_comb begin
    acc_sum = (lls_pkg::ACC_W + 1)'(acc) +
              (m_acc_en ? (lls_pkg::ACC_W + 1)'(m_prod) : '0);
    if (acc_sum[lls_pkg::ACC_W] != acc_sum[lls_pkg::ACC_W-1]) begin
      acc_sat = acc_sum[lls_pkg::ACC_W] ? {1'b1, {(lls_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(lls_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[lls_pkg::ACC_W-1:0];
    end
  end

  // margin: add bias, round to Q16.16, saturate to 32 bits
  always_comb begin
    marg_full = lls_pkg::MARG_W'(fin_sum) +
                (lls_pkg::MARG_W'(cfg.bias) <<< lls_pkg::FRAC_SHIFT) +
                signed'(lls_pkg::ROUND_HALF);
    marg_q16  = signed'(marg_full[lls_pkg::MARG_W-1:lls_pkg::FRAC_SHIFT]);
    if ((&marg_q16[lls_pkg::MARG_W-lls_pkg::FRAC_SHIFT-1:lls_pkg::SCORE_W-1]) ||
        !(|marg_q16[lls_pkg::MARG_W-lls_pkg::FRAC_SHIFT-1:lls_pkg::SCORE_W-1])) begin
      marg_sat = marg_q16[lls_pkg::SCORE_W-1:0];
    end else begin
      marg_sat = marg_q16[lls_pkg::MARG_W-lls_pkg::FRAC_SHIFT-1]
                 ? {1'b1, {(lls_pkg::SCORE_W-1){1'b0}}}
                 : {1'b0, {(lls_pkg::SCORE_W-1){1'b1}}};
    end
  end

  // sigmoid segment lookup from the magnitude of the margin
  always_comb begin
    marg_ext = (lls_pkg::SCORE_W + 1)'(margin);
    mag      = margin[lls_pkg::SCORE_W-1] ? unsigned'(-marg_ext) : unsigned'(marg_ext);
    sig_idx  = mag[lls_pkg::SIG_FRAC_W +: lls_pkg::SIG_IDX_W];
    base_pt  = lls_pkg::sig_point({1'b0, sig_idx});
    diff_pt  = lls_pkg::sig_point((lls_pkg::SIG_IDX_W + 1)'(sig_idx) + 1'b1) - base_pt;
  end

  // interpolation, mirror and result select
  always_comb begin
    rounded = (lls_pkg::SIG_PROD_W + 1)'(sig_prod) +
              (lls_pkg::SIG_PROD_W + 1)'(lls_pkg::ONE_Q16 >> 1);
    interp  = sig_big ? (lls_pkg::SIG_W + 1)'(sig_base)
                      : (lls_pkg::SIG_W + 1)'(sig_base) +
                        rounded[lls_pkg::SIG_PROD_W:lls_pkg::SIG_FRAC_W];
    prob    = sig_neg ? lls_pkg::ONE_Q16 - interp : interp;
    if (fin_err) begin
      score_next = '0;
    end else if (cfg.logistic_mode) begin
      score_next = signed'(lls_pkg::SCORE_W'(prob));
    end else begin
      score_next = margin;
    end
  end

  // state, accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      m_valid   <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
      out_score <= '0;
      out_err   <= 1'b0;
    end else begin
      if (pop) begin
        m_valid <= 1'b1;
      end else if (state == ST_RUN) begin
        m_valid <= 1'b0;
      end
      // load the result at emit, drop it once taken
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
        out_score <= score_next;
        out_err   <= fin_err;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (m_valid) begin
            if (m_eor) begin
              acc   <= '0;
              state <= ST_MARGIN;
            end else begin
              acc <= acc_sat;
            end
          end
        end
        ST_MARGIN: begin
          state <= ST_SIGMOID;
        end
        ST_SIGMOID: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod   <= lls_pkg::PROD_W'(pop_data.weight) * lls_pkg::PROD_W'(pop_data.value);
      m_acc_en <= pop_data.acc_en;
      m_eor    <= pop_data.eor;
      m_err    <= pop_data.err;
    end
    if (state == ST_RUN && m_valid && m_eor) begin
      fin_sum <= acc_sat;
      fin_err <= m_err;
    end
    if (state == ST_MARGIN) begin
      margin <= marg_sat;
    end
    if (state == ST_SIGMOID) begin
      sig_prod <= lls_pkg::SIG_PROD_W'(diff_pt) *
                  lls_pkg::SIG_PROD_W'(mag[lls_pkg::SIG_FRAC_W-1:0]);
      sig_big  <= |mag[lls_pkg::SCORE_W:lls_pkg::SIG_FRAC_W+lls_pkg::SIG_IDX_W];
      sig_base <= (|mag[lls_pkg::SCORE_W:lls_pkg::SIG_FRAC_W+lls_pkg::SIG_IDX_W])
                  ? lls_pkg::SIG_END : base_pt;
      sig_neg  <= margin[lls_pkg::SCORE_W-1];
    end
  end

  `LLS_ASSERT(a_error_scores_zero, clk, rst, out_valid && out_err |-> out_score == '0)
  `LLS_ASSERT(a_result_from_emit, clk, rst, $rose(out_valid) |-> $past(state) == ST_EMIT)
  `LLS_ASSERT(a_finish_holds_queue, clk, rst, state != ST_RUN |-> !pop)

endmodule

>>> hdl/linear_logistic_scorer_top.sv
// channel   | dir | payload
// item      | in  | kind, weight_index, value, end_of_row
// result    | out | score, row_error
// cfg       | in  | index, data (register write)
//
// a feature transaction is taken every cycle while the queue has room; the
// back-end multiply-accumulate retires one feature per cycle unless the queue
// is empty or a row is finishing; end of row holds the queue through margin,
// sigmoid lookup/multiply and result load; weight loads never enter the queue
// rst is synchronous; a result waiting on result.ready stalls the back end at
// its next result load, and the front end once the queue fills
// top level of the linear/logistic scorer: config registers and wiring
// depends on lls_pkg, lls_ifs, lls_front, lls_queue, lls_back
module linear_logistic_scorer_top (
  input  logic      clk,
  input  logic      rst,
  lls_item_if.sink  item,
  lls_result_if.source result,
  lls_cfg_if.sink   cfg
);

  lls_pkg::cfg_t cfg_regs;
  lls_pkg::job_t push_data;
  lls_pkg::job_t pop_data;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.row_len       <= lls_pkg::FC_RESET;
      cfg_regs.logistic_mode <= 1'b1;
      cfg_regs.bias          <= '0;
    end else if (cfg.valid) begin
      unique case (lls_pkg::cfg_reg_t'(cfg.index))
        lls_pkg::REG_ROW_LEN:       cfg_regs.row_len <= cfg.data[lls_pkg::POS_W-1:0];
        lls_pkg::REG_LOGISTIC_MODE: cfg_regs.logistic_mode <= cfg.data[0];
        lls_pkg::REG_BIAS:          cfg_regs.bias <= signed'(cfg.data[lls_pkg::SCORE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  lls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg_regs),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  lls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  lls_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
